### sv/contact_set_transition_tracker_unit_defines.svh
// assertion macros for the contact set transition tracker
// used by the port checker; no other dependencies
`ifndef CONTACT_SET_TRANSITION_TRACKER_UNIT_DEFINES_SVH
`define CONTACT_SET_TRANSITION_TRACKER_UNIT_DEFINES_SVH

// property that must hold at every edge outside reset
`define CSTT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define CSTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/cstt_pkg.sv
// shared types, codes and helpers of the contact set transition tracker
// no dependencies
package cstt_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam logic [31:0] SAT32_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_OFFER  = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_FLUSH  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_BEGIN = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic {
        WR_IN = 1'b0,
        WR_B  = 1'b1
    } wr_sel_t;

    typedef struct packed {
        logic [63:0] contact;
        logic [63:0] side_a;
        logic [63:0] side_b;
        logic [63:0] payload;
    } rec_t;

    typedef struct packed {
        kind_t kind;
        rec_t  rec;
    } ev_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] contact_key;
        logic [63:0] side_a_key;
        logic [63:0] side_b_key;
        logic [63:0] payload;
        logic [31:0] shape_key;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] out_contact_key;
        logic [63:0] out_side_a_key;
        logic [63:0] out_side_b_key;
        logic [63:0] out_payload;
        logic [31:0] begin_dropped;
        logic [31:0] end_dropped;
        logic        truncated;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic    capture;
        logic    rd_a;
        logic    rd_b;
        logic    wr;
        wr_sel_t wr_sel;
        logic    push;
        kind_t   push_kind;
        logic    ev_rd;
        logic    out_load;
        logic    out_ack;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        logic match_in_a;
        logic match_ab;
        logic shape_hit;
    } stat_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == SAT32_MAX) ? v : v + 32'd1;
    endfunction

endpackage

### sv/cstt_chan_if.sv
// valid/ready channel carrying one word of type T
// no dependencies
interface cstt_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### sv/cstt_dp.sv
// datapath: record memory, event buffer, key compare and output register
// depends on cstt_pkg
module cstt_dp
    import cstt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = $clog2(2 * CAPACITY)
)
(
    input  logic          clk,
    input  in_word_t      in_data,
    input  cmd_t          cmd,
    input  logic [AW-1:0] addr_a,
    input  logic [AW-1:0] addr_b,
    input  logic [AW-1:0] addr_w,
    input  logic [AW-1:0] ev_waddr,
    input  logic [AW-1:0] ev_raddr,
    output stat_t         st,
    output kind_t         out_kind,
    output rec_t          out_rec,
    output logic          out_last
);

    rec_t     rec_mem [2*CAPACITY];
    ev_t      ev_mem [2*CAPACITY];
    in_word_t in_reg;
    rec_t     rd_a_reg;
    rec_t     rd_b_reg;
    ev_t      ev_rd_reg;
    kind_t    out_kind_reg;
    rec_t     out_rec_reg;
    logic     out_last_reg;
    rec_t     in_rec;

    assign in_rec = '{contact: in_reg.contact_key, side_a: in_reg.side_a_key,
                      side_b: in_reg.side_b_key, payload: in_reg.payload};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_data;
        end
        if (cmd.wr)
        begin
            rec_mem[addr_w] <= (cmd.wr_sel == WR_B) ? rd_b_reg : in_rec;
        end
        if (cmd.rd_a)
        begin
            rd_a_reg <= rec_mem[addr_a];
        end
        if (cmd.rd_b)
        begin
            rd_b_reg <= rec_mem[addr_b];
        end
        if (cmd.push)
        begin
            ev_mem[ev_waddr] <= '{kind: cmd.push_kind, rec: rd_a_reg};
        end
        if (cmd.ev_rd)
        begin
            ev_rd_reg <= ev_mem[ev_raddr];
        end
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_ack ? KIND_ACK : ev_rd_reg.kind;
            out_rec_reg  <= cmd.out_ack ? '0 : ev_rd_reg.rec;
            out_last_reg <= cmd.out_last;
        end
    end

    always_comb
    begin
        st.match_in_a = (rd_a_reg.contact == in_reg.contact_key)
                     && (rd_a_reg.side_a == in_reg.side_a_key)
                     && (rd_a_reg.side_b == in_reg.side_b_key);
        st.match_ab   = (rd_a_reg.contact == rd_b_reg.contact)
                     && (rd_a_reg.side_a == rd_b_reg.side_a)
                     && (rd_a_reg.side_b == rd_b_reg.side_b);
        st.shape_hit  = (rd_a_reg.side_a[63:32] == in_reg.shape_key)
                     || (rd_a_reg.side_b[63:32] == in_reg.shape_key);
    end

    assign out_kind = out_kind_reg;
    assign out_rec  = out_rec_reg;
    assign out_last = out_last_reg;

endmodule

### sv/cstt_ctrl.sv
// controller: command sequencer, table counts, drop counters, event counts
// depends on cstt_pkg
module cstt_ctrl
    import cstt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = $clog2(2 * CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int EW = $clog2(2 * CAPACITY + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    in_func,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  stat_t         st,
    output cmd_t          cmd,
    output logic [AW-1:0] addr_a,
    output logic [AW-1:0] addr_b,
    output logic [AW-1:0] addr_w,
    output logic [AW-1:0] ev_waddr,
    output logic [AW-1:0] ev_raddr,
    output logic [31:0]   begin_dropped,
    output logic [31:0]   end_dropped,
    output logic          truncated
);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_OUTER_RD, S_INNER_RD, S_INNER_CHK,
        S_FL_RD, S_FL_CHK, S_FL_CP, S_EMIT, S_EMIT_LD, S_OUT_WAIT
    } state_t;

    typedef enum logic [1:0] {
        M_REPLACE, M_BEGIN, M_END
    } mode_t;

    state_t        state_reg, state_next;
    mode_t         mode_reg, mode_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] cnt_next [2];
    logic [CW-1:0] eec_reg [2];
    logic [CW-1:0] eec_next [2];
    logic [31:0]   edc_reg [2];
    logic [31:0]   edc_next [2];
    logic [CW-1:0] bec_reg, bec_next;
    logic [31:0]   bdc_reg, bdc_next;
    logic          pb_reg, pb_next;
    logic          eb_reg, eb_next;
    logic          si_reg, si_next;
    logic          ti_reg, ti_next;
    logic          ob_reg, ob_next;
    logic          sb_reg, sb_next;
    logic [EW-1:0] nev_reg, nev_next;
    logic [EW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;
    logic          cur;
    logic          prev;
    logic          is_last;
    logic          end_req;
    logic          bdc_req;

    function automatic logic [AW-1:0] slot(input logic b, input logic [CW-1:0] i);
        slot = AW'(i) + (b ? AW'(CAPACITY) : AW'(0));
    endfunction

    assign cur     = ~pb_reg;
    assign prev    = pb_reg;
    assign is_last = (nev_reg == '0) || (k_reg == EW'(nev_reg - EW'(1)));

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        eec_next       = eec_reg;
        edc_next       = edc_reg;
        bec_next       = bec_reg;
        bdc_next       = bdc_reg;
        pb_next        = pb_reg;
        eb_next        = eb_reg;
        si_next        = si_reg;
        ti_next        = ti_reg;
        ob_next        = ob_reg;
        sb_next        = sb_reg;
        nev_next       = nev_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        addr_a         = '0;
        addr_b         = '0;
        addr_w         = '0;
        ev_waddr       = nev_reg[AW-1:0];
        ev_raddr       = k_reg[AW-1:0];
        end_req        = 1'b0;
        bdc_req        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    nev_next    = '0;
                    k_next      = '0;
                    i_next      = '0;
                    case (func_t'(in_func))
                        FUNC_START:
                        begin
                            cnt_next[cur] = '0;
                            bec_next      = '0;
                            bdc_next      = '0;
                            ti_next       = si_reg;
                            state_next    = S_EMIT;
                        end
                        FUNC_OFFER:
                        begin
                            sb_next    = cur;
                            state_next = S_SRCH_RD;
                        end
                        FUNC_FINISH:
                        begin
                            si_next    = (bdc_reg != '0);
                            mode_next  = si_reg ? M_END : M_BEGIN;
                            ob_next    = si_reg ? prev : cur;
                            state_next = S_OUTER_RD;
                        end
                        FUNC_FLUSH:
                        begin
                            i_next     = cnt_reg[prev];
                            state_next = S_FL_RD;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                if (i_reg == cnt_reg[sb_reg])
                begin
                    if (sb_reg == cur)
                    begin
                        if (cnt_reg[cur] < CW'(CAPACITY))
                        begin
                            cmd.wr        = 1'b1;
                            cmd.wr_sel    = WR_IN;
                            addr_w        = slot(cur, cnt_reg[cur]);
                            cnt_next[cur] = cnt_reg[cur] + CW'(1);
                            state_next    = S_EMIT;
                        end
                        else
                        begin
                            sb_next = prev;
                            i_next  = '0;
                        end
                    end
                    else
                    begin
                        bdc_req    = 1'b1;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    cmd.rd_a   = 1'b1;
                    addr_a     = slot(sb_reg, i_reg);
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                if (st.match_in_a)
                begin
                    if (sb_reg == cur)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        mode_next  = M_REPLACE;
                        ob_next    = cur;
                        i_next     = '0;
                        state_next = S_OUTER_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_SRCH_RD;
                end
            end
            S_OUTER_RD:
            begin
                if (i_reg == cnt_reg[ob_reg])
                begin
                    case (mode_reg)
                        M_REPLACE:
                        begin
                            bdc_req    = 1'b1;
                            state_next = S_EMIT;
                        end
                        M_BEGIN:
                        begin
                            mode_next = M_END;
                            ob_next   = prev;
                            i_next    = '0;
                        end
                        default:
                        begin
                            pb_next         = cur;
                            eb_next         = ~eb_reg;
                            eec_next[~eb_reg] = '0;
                            edc_next[~eb_reg] = '0;
                            cnt_next[prev]  = '0;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
                else
                begin
                    cmd.rd_a   = 1'b1;
                    addr_a     = slot(ob_reg, i_reg);
                    j_next     = '0;
                    state_next = S_INNER_RD;
                end
            end
            S_INNER_RD:
            begin
                if (j_reg == cnt_reg[~ob_reg])
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_OUTER_RD;
                    case (mode_reg)
                        M_REPLACE:
                        begin
                            cmd.wr     = 1'b1;
                            cmd.wr_sel = WR_IN;
                            addr_w     = slot(ob_reg, i_reg);
                            bdc_req    = 1'b1;
                            state_next = S_EMIT;
                        end
                        M_BEGIN:
                        begin
                            if (bec_reg < CW'(CAPACITY))
                            begin
                                bec_next      = bec_reg + CW'(1);
                                cmd.push      = 1'b1;
                                cmd.push_kind = KIND_BEGIN;
                                nev_next      = nev_reg + EW'(1);
                            end
                            else
                            begin
                                bdc_req = 1'b1;
                            end
                        end
                        default:
                        begin
                            end_req = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    cmd.rd_b   = 1'b1;
                    addr_b     = slot(~ob_reg, j_reg);
                    state_next = S_INNER_CHK;
                end
            end
            S_INNER_CHK:
            begin
                if (st.match_ab)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_OUTER_RD;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_INNER_RD;
                end
            end
            S_FL_RD:
            begin
                if (i_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    i_next     = i_reg - CW'(1);
                    cmd.rd_a   = 1'b1;
                    addr_a     = slot(prev, i_reg - CW'(1));
                    state_next = S_FL_CHK;
                end
            end
            S_FL_CHK:
            begin
                if (st.shape_hit)
                begin
                    end_req        = 1'b1;
                    cnt_next[prev] = cnt_reg[prev] - CW'(1);
                    cmd.rd_b       = 1'b1;
                    addr_b         = slot(prev, cnt_reg[prev] - CW'(1));
                    state_next     = S_FL_CP;
                end
                else
                begin
                    state_next = S_FL_RD;
                end
            end
            S_FL_CP:
            begin
                cmd.wr     = 1'b1;
                cmd.wr_sel = WR_B;
                addr_w     = slot(prev, i_reg);
                state_next = S_FL_RD;
            end
            S_EMIT:
            begin
                if (nev_reg == '0)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_ack    = 1'b1;
                    cmd.out_last   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT_WAIT;
                end
                else
                begin
                    cmd.ev_rd  = 1'b1;
                    state_next = S_EMIT_LD;
                end
            end
            S_EMIT_LD:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = is_last;
                out_valid_next = 1'b1;
                state_next     = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    k_next         = k_reg + EW'(1);
                    state_next     = is_last ? S_IDLE : S_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end event into the active end buffer, or a drop when it is full
        if (end_req)
        begin
            if (eec_reg[eb_reg] < CW'(CAPACITY))
            begin
                eec_next[eb_reg] = eec_reg[eb_reg] + CW'(1);
                cmd.push         = 1'b1;
                cmd.push_kind    = KIND_END;
                nev_next         = nev_reg + EW'(1);
            end
            else
            begin
                edc_next[eb_reg] = sat_inc(edc_reg[eb_reg]);
            end
        end
        if (bdc_req)
        begin
            bdc_next = sat_inc(bdc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_REPLACE;
            i_reg         <= '0;
            j_reg         <= '0;
            cnt_reg       <= '{default: '0};
            eec_reg       <= '{default: '0};
            edc_reg       <= '{default: '0};
            bec_reg       <= '0;
            bdc_reg       <= '0;
            pb_reg        <= 1'b0;
            eb_reg        <= 1'b0;
            si_reg        <= 1'b0;
            ti_reg        <= 1'b0;
            ob_reg        <= 1'b0;
            sb_reg        <= 1'b0;
            nev_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            cnt_reg       <= cnt_next;
            eec_reg       <= eec_next;
            edc_reg       <= edc_next;
            bec_reg       <= bec_next;
            bdc_reg       <= bdc_next;
            pb_reg        <= pb_next;
            eb_reg        <= eb_next;
            si_reg        <= si_next;
            ti_reg        <= ti_next;
            ob_reg        <= ob_next;
            sb_reg        <= sb_next;
            nev_reg       <= nev_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign begin_dropped = bdc_reg;
    assign end_dropped   = edc_reg[~eb_reg];
    assign truncated     = ti_reg || (bdc_reg != '0) || (edc_reg[~eb_reg] != '0);

endmodule

### sv/contact_set_transition_tracker_unit.sv
// contact set transition tracker: top level joining controller and datapath
// depends on cstt_pkg, cstt_chan_if, cstt_ctrl, cstt_dp
//
// in_ch takes one command word (start, offer, finish, flush); out_ch gives
// one or more result words per command, the final one marked by last.
// a word with no event is an acknowledge of kind zero with an all-zero record.
// one command is handled at a time: in_ch.ready is high only while idle.
// offer scans the current table and, when it is full, the previous table
// and a replacement search; finish compares each table against the other,
// except that only the previous table is checked after a finish that saw
// begin drops; flush scans the previous table from its end and removes
// each entry whose side key matches the shape key. all scans share the
// single compare pair fed by two read ports of the record memory.
// when out_ch stalls the word holds and the block waits.
// reset empties both tables and clears all counts; no clearing pass.
module contact_set_transition_tracker_unit
    import cstt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = $clog2(2 * CAPACITY)
)
(
    input  logic     clk,
    input  logic     rst_n,
    cstt_chan_if.sink   in_ch,
    cstt_chan_if.source out_ch
);

    cmd_t          cmd;
    stat_t         st;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [AW-1:0] addr_w;
    logic [AW-1:0] ev_waddr;
    logic [AW-1:0] ev_raddr;
    logic [31:0]   begin_dropped;
    logic [31:0]   end_dropped;
    logic          truncated;
    kind_t         out_kind;
    rec_t          out_rec;
    logic          out_last;
    in_word_t      in_data;

    assign in_data = in_ch.data;

    cstt_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_func       (in_data.func),
        .in_ready      (in_ch.ready),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .st            (st),
        .cmd           (cmd),
        .addr_a        (addr_a),
        .addr_b        (addr_b),
        .addr_w        (addr_w),
        .ev_waddr      (ev_waddr),
        .ev_raddr      (ev_raddr),
        .begin_dropped (begin_dropped),
        .end_dropped   (end_dropped),
        .truncated     (truncated)
    );

    cstt_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk      (clk),
        .in_data  (in_data),
        .cmd      (cmd),
        .addr_a   (addr_a),
        .addr_b   (addr_b),
        .addr_w   (addr_w),
        .ev_waddr (ev_waddr),
        .ev_raddr (ev_raddr),
        .st       (st),
        .out_kind (out_kind),
        .out_rec  (out_rec),
        .out_last (out_last)
    );

    assign out_ch.data = '{
        kind:            out_kind,
        out_contact_key: out_rec.contact,
        out_side_a_key:  out_rec.side_a,
        out_side_b_key:  out_rec.side_b,
        out_payload:     out_rec.payload,
        begin_dropped:   begin_dropped,
        end_dropped:     end_dropped,
        truncated:       truncated,
        last:            out_last
    };

endmodule

### sv/cstt_checker.sv
// port checker for the contact set transition tracker, bound to the top level
// depends on cstt_pkg and the assertion macro header
`include "contact_set_transition_tracker_unit_defines.svh"

module cstt_checker
    import cstt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    `CSTT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
    `CSTT_ASSERT(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "command taken while results pending")
    `CSTT_ASSERT_NEXT(a_one_cmd, clk, rst_n, in_valid && in_ready, !in_ready, "second command taken back to back")
    `CSTT_ASSERT(a_ack_word, clk, rst_n, (out_valid && out_data.kind == KIND_ACK) |-> (out_data.last && out_data.out_contact_key == '0 && out_data.out_payload == '0), "acknowledge word malformed")

endmodule

bind contact_set_transition_tracker_unit cstt_checker u_cstt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
